// ===== src/mono_page_framebuffer_engine_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the page framebuffer engine
// Concurrent checks; they compile away when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef MONO_PAGE_FRAMEBUFFER_ENGINE_MACROS_SVH
`define MONO_PAGE_FRAMEBUFFER_ENGINE_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define MPFE_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mpfe: %m check failed");
// next-cycle implication
`define MPFE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mpfe: %m check failed");
`else
`define MPFE_ASSERT_SAME(label, clk, rst, ante, cons)
`define MPFE_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== src/mpfe_pkg.sv =====
// ---------------------------------------------------------------------------
// mpfe_pkg
// Shared types and constants of the page framebuffer engine.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package mpfe_pkg;

  localparam int COORD_W    = 9;   // window origin + relative coordinate
  localparam int STORE_AW   = 12;  // byte address, covers the largest store and chunk span
  localparam int PAGE_SHIFT = 3;   // eight rows per page
  localparam int DATA_W     = 8;
  localparam logic [2:0] BIT_TOP = 3'd7;

  typedef enum logic [1:0] {
    OP_PIXEL = 2'd0,
    OP_FILL  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    REG_WIN_LEFT   = 2'd0,
    REG_WIN_TOP    = 2'd1,
    REG_WIN_RIGHT  = 2'd2,
    REG_WIN_BOTTOM = 2'd3
  } reg_t;

  typedef enum logic [1:0] {
    MEM_NOP   = 2'd0,
    MEM_READ  = 2'd1,
    MEM_MERGE = 2'd2,
    MEM_ZERO  = 2'd3
  } mem_cmd_t;

  typedef struct packed {
    mem_cmd_t              cmd;
    logic [STORE_AW-1:0]   addr;
    logic [DATA_W-1:0]     mask;
    logic                  set;
  } mem_req_t;

endpackage

// ===== src/mono_page_framebuffer_engine.sv =====
// ---------------------------------------------------------------------------
// mono_page_framebuffer_engine
// One-bit-per-pixel framebuffer in eight-row pages. Items are handled one
// at a time by a small sequencer around a single-port store with a masked
// read-modify-write: every touched byte is read and then merged. A pixel
// draw or a fill walks setup, then a read and a merge for each store byte
// it touches (one byte covers up to eight rows of one column), with in_stall
// high from acceptance until the walk ends; a pixel or fill that misses the
// window returns to idle after setup. A clear reruns the clearing pass; a
// chunk read alternates a read and a push for each of its CHUNK_BYTES bytes,
// and a push waits while the output is stalled.
// After reset the store is zeroed by a clearing pass of one byte per cycle
// over all SCREEN_WIDTH*ceil(SCREEN_HEIGHT/8) bytes (1024 at the defaults),
// during which in_stall is high; window registers may be written meanwhile.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "mono_page_framebuffer_engine_macros.svh"

module mono_page_framebuffer_engine #(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 64,
  parameter int CHUNK_BYTES   = 16
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input items
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  operation,
  input  logic [7:0]  pos_x,
  input  logic [7:0]  pos_y,
  input  logic [7:0]  rect_width,
  input  logic [7:0]  rect_height,
  input  logic        color,
  input  logic [5:0]  chunk_index,
  // result beats
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  data_byte,
  output logic        last_byte
);
  import mpfe_pkg::*;

  localparam int PAGE_COUNT  = (SCREEN_HEIGHT + 7) / 8;
  localparam int STORE_BYTES = SCREEN_WIDTH * PAGE_COUNT;
  localparam int KW          = (CHUNK_BYTES > 1) ? $clog2(CHUNK_BYTES) : 1;
  localparam int EXT_W       = COORD_W + 1;
  localparam int PAGE_W      = COORD_W - PAGE_SHIFT;

  localparam logic [COORD_W-1:0]  X_SCR_MAX = COORD_W'(SCREEN_WIDTH - 1);
  localparam logic [COORD_W-1:0]  Y_SCR_MAX = COORD_W'(SCREEN_HEIGHT - 1);
  localparam logic [STORE_AW-1:0] CLR_LAST  = STORE_AW'(STORE_BYTES - 1);
  localparam logic [KW-1:0]       K_LAST    = KW'(CHUNK_BYTES - 1);

  typedef enum logic [6:0] {
    S_CLEAR  = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_SETUP  = 7'b0000100,
    S_FREAD  = 7'b0001000,
    S_FWRITE = 7'b0010000,
    S_RREAD  = 7'b0100000,
    S_RPUSH  = 7'b1000000
  } state_t;

  state_t state;

  // window registers
  logic [6:0] win_left;
  logic [5:0] win_top;
  logic [6:0] win_right;
  logic [5:0] win_bottom;

  // captured item
  op_t        op_q;
  logic [7:0] px_q;
  logic [7:0] py_q;
  logic [7:0] w_q;
  logic [7:0] h_q;
  logic       color_q;
  logic [5:0] chunk_q;

  // fill walk
  logic [COORD_W-1:0]  x0_q;
  logic [COORD_W-1:0]  x1_q;
  logic [COORD_W-1:0]  y0_q;
  logic [COORD_W-1:0]  y1_q;
  logic [COORD_W-1:0]  cur_x;
  logic [PAGE_W-1:0]   page;
  logic [STORE_AW-1:0] row_base;

  // readout / clear
  logic [STORE_AW-1:0] base_q;
  logic [KW-1:0]       k;
  logic                zero_q;
  logic [STORE_AW-1:0] clr_addr;

  // setup arithmetic
  logic [7:0]         wq;
  logic [7:0]         hq;
  logic [COORD_W-1:0] x0;
  logic [COORD_W-1:0] y0;
  logic [COORD_W-1:0] xmax;
  logic [COORD_W-1:0] ymax;
  logic [EXT_W-1:0]   xe;
  logic [EXT_W-1:0]   ye;
  logic [COORD_W-1:0] x1;
  logic [COORD_W-1:0] y1;
  logic               fill_ok;

  logic [STORE_AW-1:0] fill_addr;
  logic [2:0]          lo_bit;
  logic [2:0]          hi_bit;
  logic [7:0]          fill_mask;
  logic [STORE_AW-1:0] rd_addr;
  logic                rd_in_range;
  logic                cfg_write;

  mem_req_t   req;
  logic [7:0] rdata;

  mpfe_store #(
    .DEPTH (STORE_BYTES)
  ) u_store (
    .clk   (clk),
    .req   (req),
    .rdata (rdata)
  );

  // ---------------- configuration port ----------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    case (reg_t'(paddr[3:2]))
      REG_WIN_LEFT:   prdata = 32'(win_left);
      REG_WIN_TOP:    prdata = 32'(win_top);
      REG_WIN_RIGHT:  prdata = 32'(win_right);
      REG_WIN_BOTTOM: prdata = 32'(win_bottom);
      default:        prdata = '0;
    endcase
  end

  // ---------------- setup: clip against window and screen ----------------
  always_comb begin
    wq   = (op_q == OP_PIXEL) ? 8'd1 : w_q;
    hq   = (op_q == OP_PIXEL) ? 8'd1 : h_q;
    x0   = COORD_W'(px_q) + COORD_W'(win_left);
    y0   = COORD_W'(py_q) + COORD_W'(win_top);
    xmax = (COORD_W'(win_right) <= X_SCR_MAX) ? COORD_W'(win_right) : X_SCR_MAX;
    ymax = (COORD_W'(win_bottom) <= Y_SCR_MAX) ? COORD_W'(win_bottom) : Y_SCR_MAX;
    xe   = EXT_W'(x0) + EXT_W'(wq) - EXT_W'(1);
    ye   = EXT_W'(y0) + EXT_W'(hq) - EXT_W'(1);
    x1   = (xe > EXT_W'(xmax)) ? xmax : xe[COORD_W-1:0];
    y1   = (ye > EXT_W'(ymax)) ? ymax : ye[COORD_W-1:0];
    fill_ok = (wq != 8'd0) && (hq != 8'd0) && (x0 <= xmax) && (y0 <= ymax);
  end

  // ---------------- walk addressing ----------------
  always_comb begin
    fill_addr = row_base + STORE_AW'(cur_x);
    lo_bit    = (page == y0_q[COORD_W-1:PAGE_SHIFT]) ? y0_q[2:0] : 3'd0;
    hi_bit    = (page == y1_q[COORD_W-1:PAGE_SHIFT]) ? y1_q[2:0] : BIT_TOP;
    fill_mask = (8'hFF << lo_bit) & (8'hFF >> (BIT_TOP - hi_bit));
    rd_addr     = base_q + STORE_AW'(k);
    rd_in_range = {1'b0, rd_addr} < (STORE_AW + 1)'(STORE_BYTES);
  end

  always_comb begin
    req = '0;
    case (state)
      S_CLEAR: begin
        req.cmd  = MEM_ZERO;
        req.addr = clr_addr;
      end
      S_FREAD: begin
        req.cmd  = MEM_READ;
        req.addr = fill_addr;
      end
      S_FWRITE: begin
        req.cmd  = MEM_MERGE;
        req.addr = fill_addr;
        req.mask = fill_mask;
        req.set  = color_q;
      end
      S_RREAD: begin
        if (rd_in_range) begin
          req.cmd  = MEM_READ;
          req.addr = rd_addr;
        end
      end
      default: ;
    endcase
  end

  assign in_stall = (state != S_IDLE);

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      out_valid  <= 1'b0;
      win_left   <= 7'd0;
      win_top    <= 6'd0;
      win_right  <= 7'd127;
      win_bottom <= 6'd63;
    end else begin
      if (cfg_write) begin
        case (reg_t'(paddr[3:2]))
          REG_WIN_LEFT:   win_left   <= pwdata[6:0];
          REG_WIN_TOP:    win_top    <= pwdata[5:0];
          REG_WIN_RIGHT:  win_right  <= pwdata[6:0];
          REG_WIN_BOTTOM: win_bottom <= pwdata[5:0];
          default: ;
        endcase
      end

      // in S_RPUSH the output register is reloaded below
      if (out_valid && !out_stall && (state != S_RPUSH)) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + STORE_AW'(1);
          if (clr_addr == CLR_LAST) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            op_q    <= op_t'(operation);
            px_q    <= pos_x;
            py_q    <= pos_y;
            w_q     <= rect_width;
            h_q     <= rect_height;
            color_q <= color;
            chunk_q <= chunk_index;
            state   <= S_SETUP;
          end
        end
        S_SETUP: begin
          case (op_q)
            OP_CLEAR: begin
              clr_addr <= '0;
              state    <= S_CLEAR;
            end
            OP_READ: begin
              base_q <= STORE_AW'(chunk_q) * STORE_AW'(CHUNK_BYTES);
              k      <= '0;
              state  <= S_RREAD;
            end
            default: begin
              x0_q     <= x0;
              x1_q     <= x1;
              y0_q     <= y0;
              y1_q     <= y1;
              cur_x    <= x0;
              page     <= y0[COORD_W-1:PAGE_SHIFT];
              row_base <= STORE_AW'(y0[COORD_W-1:PAGE_SHIFT]) * STORE_AW'(SCREEN_WIDTH);
              state    <= fill_ok ? S_FREAD : S_IDLE;
            end
          endcase
        end
        S_FREAD: begin
          state <= S_FWRITE;
        end
        S_FWRITE: begin
          if (cur_x == x1_q) begin
            if (page == y1_q[COORD_W-1:PAGE_SHIFT]) begin
              state <= S_IDLE;
            end else begin
              page     <= page + PAGE_W'(1);
              row_base <= row_base + STORE_AW'(SCREEN_WIDTH);
              cur_x    <= x0_q;
              state    <= S_FREAD;
            end
          end else begin
            cur_x <= cur_x + COORD_W'(1);
            state <= S_FREAD;
          end
        end
        S_RREAD: begin
          zero_q <= !rd_in_range;
          state  <= S_RPUSH;
        end
        S_RPUSH: begin
          if (!out_valid || !out_stall) begin
            data_byte <= zero_q ? 8'd0 : rdata;
            last_byte <= (k == K_LAST);
            out_valid <= 1'b1;
            if (k == K_LAST) begin
              state <= S_IDLE;
            end else begin
              k     <= k + KW'(1);
              state <= S_RREAD;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // ---------------- checks ----------------
  `MPFE_ASSERT_NEXT(a_accept_setup, clk, rst, in_valid && !in_stall, state == S_SETUP)
  `MPFE_ASSERT_NEXT(a_beat_only_from_read, clk, rst, (state != S_RPUSH) && out_valid && !out_stall, !out_valid)
  `MPFE_ASSERT_SAME(a_mask_nonzero, clk, rst, state == S_FWRITE, fill_mask != 8'h00)
  `MPFE_ASSERT_SAME(a_walk_bounds, clk, rst, state == S_FWRITE, (cur_x <= x1_q) && (page <= y1_q[COORD_W-1:PAGE_SHIFT]))

endmodule

// ===== src/mpfe_store.sv =====
// ---------------------------------------------------------------------------
// mpfe_store
// Pixel byte store with registered read and a masked merge write that
// combines the last read byte with a set or clear mask.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module mpfe_store #(
  parameter int DEPTH = 1024
) (
  input  logic                clk,
  input  mpfe_pkg::mem_req_t  req,
  output logic [7:0]          rdata
);
  import mpfe_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [AW-1:0]     idx;
  logic [DATA_W-1:0] wdata;

  assign idx = req.addr[AW-1:0];

  // merge relies on rdata holding the byte from the preceding read
  always_comb begin
    if (req.set) begin
      wdata = rdata | req.mask;
    end else begin
      wdata = rdata & ~req.mask;
    end
  end

  always_ff @(posedge clk) begin
    if (req.cmd == MEM_READ) begin
      rdata <= mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    case (req.cmd)
      MEM_MERGE: mem[idx] <= wdata;
      MEM_ZERO:  mem[idx] <= '0;
      default: ;
    endcase
  end

endmodule

// ===== bench/testbench.sv =====
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the page framebuffer engine. Draws, fills, clears
// and chunk reads go in over the item port while an internal copy of the
// framebuffer predicts every readout beat. The window registers are written
// between phases over the APB port, and both handshakes idle at random.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import mpfe_pkg::*;

  localparam int SCREEN_W     = 128;
  localparam int SCREEN_H     = 64;
  localparam int CHUNK_LEN    = 16;
  localparam int STORE_LEN    = SCREEN_W * ((SCREEN_H + 7) / 8);
  // worst single item: a full-screen fill, a read and a merge per store byte
  localparam int DRAIN_CYCLES = 2 * STORE_LEN + 150;
  localparam int HOLD_CYCLES  = 400;
  localparam int LIMIT_CYCLES = 2_000_000;

  typedef struct {
    op_t        op;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] w;
    logic [7:0] h;
    logic       c;
    logic [5:0] chunk;
  } fb_cmd_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } out_beat_t;

  logic        clk         = 1'b0;
  logic        rst         = 1'b1;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [3:0]  paddr       = '0;
  logic [31:0] pwdata      = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid    = 1'b0;
  logic        in_stall;
  logic [1:0]  operation   = '0;
  logic [7:0]  pos_x       = '0;
  logic [7:0]  pos_y       = '0;
  logic [7:0]  rect_width  = '0;
  logic [7:0]  rect_height = '0;
  logic        color       = 1'b0;
  logic [5:0]  chunk_index = '0;
  logic        out_valid;
  logic        out_stall   = 1'b0;
  logic [7:0]  data_byte;
  logic        last_byte;

  // predictor state
  logic [7:0]  page_bytes [STORE_LEN];
  int          win_left   = 0;
  int          win_top    = 0;
  int          win_right  = 127;
  int          win_bottom = 63;
  out_beat_t   chunk_beats_due [$];

  int  errors = 0;
  int  cycle_count = 0;
  int  beats_checked = 0;
  int  n_pixel = 0, n_fill = 0, n_clear = 0, n_read = 0;
  bit  quiet = 1'b0;
  int  pressure_requests = 0;
  int  pressure_seen = 0;
  int  hold_left = 0;

  mono_page_framebuffer_engine dut (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .operation  (operation),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .rect_width (rect_width),
    .rect_height(rect_height),
    .color      (color),
    .chunk_index(chunk_index),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .data_byte  (data_byte),
    .last_byte  (last_byte)
  );

  always #4 clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // ---- predictor ----------------------------------------------------------
  function automatic void plot_pixel(input int xx, input int yy, input logic c);
    int addr;
    if (xx >= SCREEN_W || yy >= SCREEN_H) return;
    addr = xx + (yy / 8) * SCREEN_W;
    page_bytes[addr][yy % 8] = c;
  endfunction

  task automatic predict_item(input fb_cmd_t cmd);
    int x0, y0, x1, y1, base;
    out_beat_t beat;
    x0 = cmd.x + win_left;
    y0 = cmd.y + win_top;
    case (cmd.op)
      OP_PIXEL: begin
        n_pixel++;
        if (x0 <= win_right && y0 <= win_bottom) plot_pixel(x0, y0, cmd.c);
      end
      OP_FILL: begin
        n_fill++;
        if (cmd.w != 0 && cmd.h != 0 && x0 <= win_right && y0 <= win_bottom) begin
          x1 = x0 + cmd.w - 1;
          y1 = y0 + cmd.h - 1;
          if (x1 > win_right) x1 = win_right;
          if (y1 > win_bottom) y1 = win_bottom;
          for (int yy = y0; yy <= y1; yy++)
            for (int xx = x0; xx <= x1; xx++)
              plot_pixel(xx, yy, cmd.c);
        end
      end
      OP_CLEAR: begin
        n_clear++;
        foreach (page_bytes[i]) page_bytes[i] = '0;
      end
      default: begin
        n_read++;
        base = cmd.chunk * CHUNK_LEN;
        for (int k = 0; k < CHUNK_LEN; k++) begin
          // bytes past the store read as zero
          beat.data = (base + k < STORE_LEN) ? page_bytes[base + k] : 8'h00;
          beat.last = (k == CHUNK_LEN - 1);
          chunk_beats_due.push_back(beat);
        end
      end
    endcase
  endtask

  // ---- drivers ------------------------------------------------------------
  function automatic fb_cmd_t item_of(input op_t op, input int x, input int y,
                                      input int w, input int h, input int c,
                                      input int chunk);
    fb_cmd_t cmd;
    cmd.op = op;
    cmd.x = 8'(x);
    cmd.y = 8'(y);
    cmd.w = 8'(w);
    cmd.h = 8'(h);
    cmd.c = 1'(c);
    cmd.chunk = 6'(chunk);
    return cmd;
  endfunction

  function automatic logic [7:0] random_extent();
    int pick;
    pick = $urandom_range(19);
    if (pick == 0) return 8'd0;
    if (pick < 3) return 8'($urandom);
    return 8'($urandom_range(16, 1));
  endfunction

  function automatic fb_cmd_t random_cmd();
    fb_cmd_t cmd;
    int pick;
    pick = $urandom_range(99);
    cmd.op = (pick < 35) ? OP_PIXEL : (pick < 65) ? OP_FILL : (pick < 95) ? OP_READ : OP_CLEAR;
    cmd.x = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(40));
    cmd.y = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(24));
    cmd.w = random_extent();
    cmd.h = random_extent();
    cmd.c = 1'($urandom_range(1));
    cmd.chunk = 6'($urandom);
    return cmd;
  endfunction

  task automatic send_item(input fb_cmd_t cmd);
    while (!quiet && $urandom_range(99) < 28) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    operation   <= cmd.op;
    pos_x       <= cmd.x;
    pos_y       <= cmd.y;
    rect_width  <= cmd.w;
    rect_height <= cmd.h;
    color       <= cmd.c;
    chunk_index <= cmd.chunk;
    in_valid    <= 1'b1;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    predict_item(cmd);
  endtask

  // waits out outstanding beats, then the longest no-result item
  task automatic settle_block();
    int waited;
    in_valid <= 1'b0;
    waited = 0;
    while (chunk_beats_due.size() != 0 && waited < 8 * DRAIN_CYCLES) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // setup then access; the caller returns the bus to idle
  task automatic write_window_reg(input reg_t idx, input int value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    case (idx)
      REG_WIN_LEFT:   win_left   = value & 8'h7F;
      REG_WIN_TOP:    win_top    = value & 8'h3F;
      REG_WIN_RIGHT:  win_right  = value & 8'h7F;
      REG_WIN_BOTTOM: win_bottom = value & 8'h3F;
      default: ;
    endcase
  endtask

  task automatic set_window(input int l, input int t, input int r, input int b);
    write_window_reg(REG_WIN_LEFT, l);
    write_window_reg(REG_WIN_TOP, t);
    write_window_reg(REG_WIN_RIGHT, r);
    write_window_reg(REG_WIN_BOTTOM, b);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // ---- result side --------------------------------------------------------
  always @(posedge clk) begin
    if (hold_left == 0 && pressure_seen != pressure_requests) begin
      pressure_seen = pressure_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !quiet && ($urandom_range(99) < 28);
    end
  end

  always @(posedge clk) begin : check_readout
    out_beat_t due;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      beats_checked++;
      if (chunk_beats_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat: expected none, got data %h last %b",
                 $time, data_byte, last_byte);
      end else begin
        due = chunk_beats_due.pop_front();
        if (data_byte !== due.data) begin
          errors++;
          $display("%0t: data_byte mismatch: expected %h, got %h",
                   $time, due.data, data_byte);
        end
        if (last_byte !== due.last) begin
          errors++;
          $display("%0t: last_byte mismatch: expected %b, got %b",
                   $time, due.last, last_byte);
        end
      end
    end
  end

  // ---- tests --------------------------------------------------------------
  task automatic test_directed();
    send_item(item_of(OP_PIXEL, 0, 0, 0, 0, 1, 0));
    send_item(item_of(OP_PIXEL, 127, 63, 0, 0, 1, 0));
    send_item(item_of(OP_PIXEL, 128, 0, 0, 0, 1, 0));      // past right edge
    send_item(item_of(OP_PIXEL, 0, 64, 0, 0, 1, 0));       // past bottom edge
    send_item(item_of(OP_PIXEL, 255, 255, 255, 255, 1, 63));
    send_item(item_of(OP_READ, 0, 0, 0, 0, 0, 0));
    send_item(item_of(OP_READ, 255, 255, 255, 255, 1, 63));
    send_item(item_of(OP_FILL, 10, 10, 0, 5, 1, 0));       // zero width
    send_item(item_of(OP_FILL, 10, 10, 5, 0, 1, 0));       // zero height
    send_item(item_of(OP_FILL, 120, 60, 255, 255, 1, 0));  // corner clamped
    send_item(item_of(OP_READ, 0, 0, 0, 0, 0, 63));
    send_item(item_of(OP_FILL, 3, 2, 6, 13, 1, 0));
    send_item(item_of(OP_FILL, 4, 5, 2, 3, 0, 0));
    send_item(item_of(OP_READ, 0, 0, 0, 0, 0, 0));
    send_item(item_of(OP_PIXEL, 3, 2, 0, 0, 0, 0));
    send_item(item_of(OP_READ, 0, 0, 0, 0, 0, 8));
    send_item(item_of(OP_FILL, 0, 0, 255, 255, 1, 0));
    send_item(item_of(OP_READ, 0, 0, 0, 0, 0, 27));
    send_item(item_of(OP_CLEAR, 0, 0, 0, 0, 0, 0));
    send_item(item_of(OP_READ, 0, 0, 0, 0, 0, 0));
    send_item(item_of(OP_READ, 0, 0, 0, 0, 0, 63));
    settle_block();
  endtask

  task automatic test_window_settings();
    int l, t, r, b;
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: begin l = 127; t = 63; r = 127; b = 63; end
        1: begin l = 0;   t = 0;  r = 0;   b = 0;  end
        2: begin l = 100; t = 40; r = 10;  b = 5;  end  // inverted window
        6: begin l = 0;   t = 0;  r = 127; b = 63; end
        default: begin
          l = $urandom_range(80);
          t = $urandom_range(40);
          r = $urandom_range(127, l);
          b = $urandom_range(63, t);
        end
      endcase
      set_window(l, t, r, b);
      for (int i = 0; i < 14; i++) send_item(random_cmd());
      send_item(item_of(OP_READ, 0, 0, 0, 0, 0, $urandom_range(7)));
      send_item(item_of(OP_READ, 0, 0, 0, 0, 0, $urandom_range(63)));
      settle_block();
    end
  endtask

  task automatic test_random_traffic();
    for (int i = 0; i < 100; i++) begin
      quiet = (i >= 30 && i < 70);
      send_item(random_cmd());
    end
    quiet = 1'b0;
  endtask

  // long output hold-off while reads keep coming: the block must stall input
  task automatic test_backpressure();
    pressure_requests++;
    for (int i = 0; i < 12; i++)
      send_item(item_of(OP_READ, 0, 0, 0, 0, 0, $urandom_range(63)));
  endtask

  initial begin
    wait (cycle_count >= LIMIT_CYCLES);
    $display("timeout after %0d cycles, %0d beats still due",
             cycle_count, chunk_beats_due.size());
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    foreach (page_bytes[i]) page_bytes[i] = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_window_settings();
    test_random_traffic();
    test_backpressure();
    settle_block();
    if (chunk_beats_due.size() != 0) begin
      errors++;
      $display("%0t: %0d readout beats never arrived", $time, chunk_beats_due.size());
    end
    $display("items: %0d draws, %0d fills, %0d clears, %0d reads; 7 window settings",
             n_pixel, n_fill, n_clear, n_read);
    $display("readout beats checked: %0d, errors: %0d", beats_checked, errors);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
